### src/gtg_pkg.sv
// shared types, constants and the arctangent table of the go-to-goal steering unit
`timescale 1ns / 1ps

package gtg_pkg;

    // register indexes on the configuration channel
    localparam logic [2:0] CFG_TURN_GAIN      = 3'd0;
    localparam logic [2:0] CFG_SPEED_GAIN     = 3'd1;
    localparam logic [2:0] CFG_TURN_FLOOR     = 3'd2;
    localparam logic [2:0] CFG_GOAL_TOLERANCE = 3'd3;

    localparam logic [11:0] TURN_GAIN_RST      = 12'd1280;
    localparam logic [11:0] SPEED_GAIN_RST     = 12'd128;
    localparam logic [11:0] TURN_FLOOR_RST     = 12'd128;
    localparam logic [14:0] GOAL_TOLERANCE_RST = 15'd102;

    // angle constants
    localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
    localparam logic signed [16:0] PI_Q12      = 17'sd12868;
    localparam logic signed [16:0] TWO_PI_Q12  = 17'sd25736;

    // datapath widths
    localparam int XY_W  = 28;
    localparam int Z_W   = 20;
    localparam int SQ_W  = 34;
    localparam int REM_W = 29;

    // atan(2^-i) in units of 2^-16 rad
    function automatic logic signed [19:0] atan_q16(input int i);
        logic signed [19:0] a;
        unique case (i)
            0:  a = 20'sd51472;
            1:  a = 20'sd30385;
            2:  a = 20'sd16055;
            3:  a = 20'sd8150;
            4:  a = 20'sd4091;
            5:  a = 20'sd2047;
            6:  a = 20'sd1024;
            7:  a = 20'sd512;
            8:  a = 20'sd256;
            9:  a = 20'sd128;
            10: a = 20'sd64;
            11: a = 20'sd32;
            12: a = 20'sd16;
            13: a = 20'sd8;
            14: a = 20'sd4;
            15: a = 20'sd2;
            16: a = 20'sd1;
            default: a = 20'sd0;
        endcase
        return a;
    endfunction

    // side data riding along the bearing cells
    typedef struct packed {
        logic [32:0]        sqx;
        logic [32:0]        sqy;
        logic signed [14:0] hd;
        logic               atg;
        logic               zero;
    } cordic_pass_t;

    // side data riding along the root cells
    typedef struct packed {
        logic signed [15:0] turn;
        logic [15:0]        div;
        logic               atg;
    } sqrt_pass_t;

    // side data riding along the divider cells
    typedef struct packed {
        logic signed [15:0] turn;
        logic               atg;
        logic               sat;
    } div_pass_t;

endpackage

### src/go_to_goal_steering_unit.sv
// top level of the go-to-goal steering unit
`timescale 1ns / 1ps
// proportional go-to-goal steering, fully pipelined
// usage:
//   - an item (robot pose plus goal point) is taken at a rising edge with start
//     high and busy low; busy never rises, so one item can enter every cycle
//   - each item yields one result (turn_rate, forward_speed, at_goal) shown for
//     exactly one cycle with done high; the receiver cannot stall
//   - throughput is one item per cycle
//   - the latency is set by the cell chains: CORDIC_STAGES bearing cells,
//     17 root cells for the distance and 16 divider cells for the speed,
//     plus eight single stages around them
//   - configuration writes go through cfg_valid / cfg_ready with cfg_index and
//     cfg_data; cfg_ready is always high, unknown indexes are dropped
//   - write configuration only while no item is in flight
//   - reset clears all valid bits and loads the default gains, floor and
//     tolerance; no memory needs clearing
module go_to_goal_steering_unit
    import gtg_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] robot_x,
    input  logic signed [15:0] robot_y,
    input  logic signed [14:0] robot_heading,
    input  logic signed [15:0] target_x,
    input  logic signed [15:0] target_y,
    output logic               done,
    output logic signed [15:0] turn_rate,
    output logic [15:0]        forward_speed,
    output logic               at_goal,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int N       = CORDIC_STAGES;
    localparam int CPW     = $bits(cordic_pass_t);
    localparam int SPW     = $bits(sqrt_pass_t);
    localparam int DPW     = $bits(div_pass_t);
    localparam int SQ_CELLS  = 17;
    localparam int DIV_CELLS = 16;

    // configuration registers
    logic [11:0] turn_gain_reg, speed_gain_reg, turn_floor_reg;
    logic [14:0] goal_tol_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turn_gain_reg  <= TURN_GAIN_RST;
            speed_gain_reg <= SPEED_GAIN_RST;
            turn_floor_reg <= TURN_FLOOR_RST;
            goal_tol_reg   <= GOAL_TOLERANCE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_TURN_GAIN:      turn_gain_reg  <= cfg_data[11:0];
                CFG_SPEED_GAIN:     speed_gain_reg <= cfg_data[11:0];
                CFG_TURN_FLOOR:     turn_floor_reg <= cfg_data[11:0];
                CFG_GOAL_TOLERANCE: goal_tol_reg   <= cfg_data[14:0];
                default:            ;
            endcase
        end
    end

    // stage a: goal offset
    logic               a_v_reg;
    logic signed [16:0] a_dx_reg, a_dy_reg;
    logic signed [14:0] a_hd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_v_reg <= 1'b0;
        else
            a_v_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        a_dx_reg <= {target_x[15], target_x} - {robot_x[15], robot_x};
        a_dy_reg <= {target_y[15], target_y} - {robot_y[15], robot_y};
        a_hd_reg <= robot_heading;
    end

    // stage b: quadrant turn, squares and arrival test
    logic signed [XY_W-1:0] xs256, ys256, b_x_next, b_y_next;
    logic signed [Z_W-1:0]  b_z_next;
    logic [16:0]            adx, ady;
    cordic_pass_t           b_p_next;

    assign xs256 = XY_W'(a_dx_reg) <<< 8;
    assign ys256 = XY_W'(a_dy_reg) <<< 8;
    assign adx   = a_dx_reg[16] ? 17'(-a_dx_reg) : 17'(a_dx_reg);
    assign ady   = a_dy_reg[16] ? 17'(-a_dy_reg) : 17'(a_dy_reg);

    always_comb
    begin
        b_x_next = xs256;
        b_y_next = ys256;
        b_z_next = '0;
        if (a_dx_reg[16])
        begin
            if (!a_dy_reg[16])
            begin
                b_x_next = ys256;
                b_y_next = -xs256;
                b_z_next = HALF_PI_Q16;
            end
            else
            begin
                b_x_next = -ys256;
                b_y_next = xs256;
                b_z_next = -HALF_PI_Q16;
            end
        end
        b_p_next.sqx  = 33'(34'(adx) * 34'(adx));
        b_p_next.sqy  = 33'(34'(ady) * 34'(ady));
        b_p_next.hd   = a_hd_reg;
        b_p_next.atg  = (adx <= {2'b0, goal_tol_reg}) && (ady <= {2'b0, goal_tol_reg});
        b_p_next.zero = (a_dx_reg == '0) && (a_dy_reg == '0);
    end

    // bearing cell chain
    logic                   c_v [0:N];
    logic signed [XY_W-1:0] c_x [0:N];
    logic signed [XY_W-1:0] c_y [0:N];
    logic signed [Z_W-1:0]  c_z [0:N];
    logic [CPW-1:0]         c_p [0:N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_v[0] <= 1'b0;
        else
            c_v[0] <= a_v_reg;
    end

    always_ff @(posedge clk)
    begin
        c_x[0] <= b_x_next;
        c_y[0] <= b_y_next;
        c_z[0] <= b_z_next;
        c_p[0] <= b_p_next;
    end

    for (genvar i = 0; i < N; i++)
    begin : g_cordic
        gtg_cordic_cell #(.I(i), .PW(CPW)) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .v_in  (c_v[i]),
            .x_in  (c_x[i]),
            .y_in  (c_y[i]),
            .z_in  (c_z[i]),
            .p_in  (c_p[i]),
            .v_out (c_v[i+1]),
            .x_out (c_x[i+1]),
            .y_out (c_y[i+1]),
            .z_out (c_z[i+1]),
            .p_out (c_p[i+1])
        );
    end

    // stage d: heading error with a single wrap, sum of squares
    cordic_pass_t       cp;
    logic signed [Z_W-1:0] z_rnd;
    logic signed [16:0] bearing, err_raw, err_wrap;
    logic               d_v_reg;
    logic signed [16:0] d_err_reg;
    logic [SQ_W-1:0]    d_sq_reg;
    logic               d_atg_reg;

    assign cp      = cordic_pass_t'(c_p[N]);
    assign z_rnd   = (c_z[N] + Z_W'(8)) >>> 4;
    assign bearing = cp.zero ? 17'sd0 : 17'(z_rnd);
    assign err_raw = bearing - 17'(cp.hd);

    always_comb
    begin
        if (err_raw < -PI_Q12)
            err_wrap = err_raw + TWO_PI_Q12;
        else if (err_raw > PI_Q12)
            err_wrap = err_raw - TWO_PI_Q12;
        else
            err_wrap = err_raw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_v_reg <= 1'b0;
        else
            d_v_reg <= c_v[N];
    end

    always_ff @(posedge clk)
    begin
        d_err_reg <= err_wrap;
        d_sq_reg  <= SQ_W'(cp.sqx) + SQ_W'(cp.sqy);
        d_atg_reg <= cp.atg;
    end

    // stage e: gain product
    logic               e_v_reg;
    logic signed [29:0] e_prod_reg;
    logic [SQ_W-1:0]    e_sq_reg;
    logic               e_atg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_v_reg <= 1'b0;
        else
            e_v_reg <= d_v_reg;
    end

    always_ff @(posedge clk)
    begin
        e_prod_reg <= 30'($signed({1'b0, turn_gain_reg})) * 30'(d_err_reg) + 30'sd2048;
        e_sq_reg   <= d_sq_reg;
        e_atg_reg  <= d_atg_reg;
    end

    // stage f: round, saturate, divisor floor
    logic signed [17:0] turn_wide;
    logic signed [15:0] turn_sat;
    logic [15:0]        turn_abs, floor_eff, div_sel;
    logic               f_v_reg;
    sqrt_pass_t         f_p_reg;
    logic [SQ_W-1:0]    f_sq_reg;

    assign turn_wide = 18'(e_prod_reg >>> 12);

    always_comb
    begin
        if (turn_wide > 18'sd32767)
            turn_sat = 16'sh7fff;
        else if (turn_wide < -18'sd32768)
            turn_sat = 16'sh8000;
        else
            turn_sat = turn_wide[15:0];
    end

    assign turn_abs  = turn_sat[15] ? 16'(-turn_sat) : 16'(turn_sat);
    assign floor_eff = (turn_floor_reg == '0) ? 16'd1 : {4'd0, turn_floor_reg};
    assign div_sel   = (turn_abs < floor_eff) ? floor_eff : turn_abs;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_v_reg <= 1'b0;
        else
            f_v_reg <= e_v_reg;
    end

    always_ff @(posedge clk)
    begin
        f_p_reg.turn <= turn_sat;
        f_p_reg.div  <= div_sel;
        f_p_reg.atg  <= e_atg_reg;
        f_sq_reg     <= e_sq_reg;
    end

    // distance root chain
    logic            s_v    [0:SQ_CELLS];
    logic [SQ_W-1:0] s_val  [0:SQ_CELLS];
    logic [SQ_W-1:0] s_root [0:SQ_CELLS];
    logic [SPW-1:0]  s_p    [0:SQ_CELLS];

    assign s_v[0]    = f_v_reg;
    assign s_val[0]  = f_sq_reg;
    assign s_root[0] = '0;
    assign s_p[0]    = f_p_reg;

    for (genvar j = 0; j < SQ_CELLS; j++)
    begin : g_sqrt
        gtg_sqrt_cell #(.K(SQ_CELLS - 1 - j), .PW(SPW)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .v_in     (s_v[j]),
            .val_in   (s_val[j]),
            .root_in  (s_root[j]),
            .p_in     (s_p[j]),
            .v_out    (s_v[j+1]),
            .val_out  (s_val[j+1]),
            .root_out (s_root[j+1]),
            .p_out    (s_p[j+1])
        );
    end

    // stage g: dividend and divisor
    sqrt_pass_t         sp;
    logic               g_v_reg;
    logic [REM_W-1:0]   g_num_reg;
    logic [17:0]        g_den_reg;
    logic signed [15:0] g_turn_reg;
    logic               g_atg_reg;

    assign sp = sqrt_pass_t'(s_p[SQ_CELLS]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            g_v_reg <= 1'b0;
        else
            g_v_reg <= s_v[SQ_CELLS];
    end

    always_ff @(posedge clk)
    begin
        g_num_reg  <= REM_W'(speed_gain_reg) * REM_W'(s_root[SQ_CELLS][16:0]);
        g_den_reg  <= {sp.div, 2'b00};
        g_turn_reg <= sp.turn;
        g_atg_reg  <= sp.atg;
    end

    // stage g2: overflow test, quotient would reach 2^16
    logic             h_v_reg;
    logic [REM_W-1:0] h_num_reg;
    logic [17:0]      h_den_reg;
    div_pass_t        h_p_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            h_v_reg <= 1'b0;
        else
            h_v_reg <= g_v_reg;
    end

    always_ff @(posedge clk)
    begin
        h_num_reg    <= g_num_reg;
        h_den_reg    <= g_den_reg;
        h_p_reg.turn <= g_turn_reg;
        h_p_reg.atg  <= g_atg_reg;
        h_p_reg.sat  <= {5'd0, g_num_reg} >= {g_den_reg, 16'd0};
    end

    // speed divider chain
    logic             q_v   [0:DIV_CELLS];
    logic [REM_W-1:0] q_rem [0:DIV_CELLS];
    logic [17:0]      q_den [0:DIV_CELLS];
    logic [15:0]      q_quo [0:DIV_CELLS];
    logic [DPW-1:0]   q_p   [0:DIV_CELLS];

    assign q_v[0]   = h_v_reg;
    assign q_rem[0] = h_num_reg;
    assign q_den[0] = h_den_reg;
    assign q_quo[0] = '0;
    assign q_p[0]   = h_p_reg;

    for (genvar k = 0; k < DIV_CELLS; k++)
    begin : g_div
        gtg_div_cell #(.B(DIV_CELLS - 1 - k), .PW(DPW)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .v_in    (q_v[k]),
            .rem_in  (q_rem[k]),
            .den_in  (q_den[k]),
            .quo_in  (q_quo[k]),
            .p_in    (q_p[k]),
            .v_out   (q_v[k+1]),
            .rem_out (q_rem[k+1]),
            .den_out (q_den[k+1]),
            .quo_out (q_quo[k+1]),
            .p_out   (q_p[k+1])
        );
    end

    // output register
    div_pass_t          dp;
    logic               done_reg;
    logic signed [15:0] turn_rate_reg;
    logic [15:0]        speed_reg;
    logic               at_goal_reg;

    assign dp = div_pass_t'(q_p[DIV_CELLS]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= q_v[DIV_CELLS];
    end

    always_ff @(posedge clk)
    begin
        turn_rate_reg <= dp.turn;
        speed_reg     <= dp.sat ? 16'hffff : q_quo[DIV_CELLS];
        at_goal_reg   <= dp.atg;
    end

    assign done          = done_reg;
    assign turn_rate     = turn_rate_reg;
    assign forward_speed = speed_reg;
    assign at_goal       = at_goal_reg;

endmodule

### src/gtg_cordic_cell.sv
// one vectoring rotation step of the bearing chain
`timescale 1ns / 1ps

module gtg_cordic_cell
    import gtg_pkg::*;
#(
    parameter int I  = 0,
    parameter int PW = 1
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   v_in,
    input  logic signed [XY_W-1:0] x_in,
    input  logic signed [XY_W-1:0] y_in,
    input  logic signed [Z_W-1:0]  z_in,
    input  logic [PW-1:0]          p_in,
    output logic                   v_out,
    output logic signed [XY_W-1:0] x_out,
    output logic signed [XY_W-1:0] y_out,
    output logic signed [Z_W-1:0]  z_out,
    output logic [PW-1:0]          p_out
);

    logic signed [XY_W-1:0] xs, ys, x_next, y_next;
    logic signed [Z_W-1:0]  z_next;
    logic                   v_reg;
    logic signed [XY_W-1:0] x_reg, y_reg;
    logic signed [Z_W-1:0]  z_reg;
    logic [PW-1:0]          p_reg;

    assign xs = x_in >>> I;
    assign ys = y_in >>> I;

    always_comb
    begin
        if (!y_in[XY_W-1])
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + atan_q16(I);
        end
        else
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - atan_q16(I);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else
            v_reg <= v_in;
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        p_reg <= p_in;
    end

    assign v_out = v_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
    assign p_out = p_reg;

endmodule

### src/gtg_sqrt_cell.sv
// one root bit of the distance chain
`timescale 1ns / 1ps

module gtg_sqrt_cell
    import gtg_pkg::*;
#(
    parameter int K  = 0,
    parameter int PW = 1
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            v_in,
    input  logic [SQ_W-1:0] val_in,
    input  logic [SQ_W-1:0] root_in,
    input  logic [PW-1:0]   p_in,
    output logic            v_out,
    output logic [SQ_W-1:0] val_out,
    output logic [SQ_W-1:0] root_out,
    output logic [PW-1:0]   p_out
);

    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * K);

    logic [SQ_W-1:0] trial, val_next, root_next;
    logic            v_reg;
    logic [SQ_W-1:0] val_reg, root_reg;
    logic [PW-1:0]   p_reg;

    assign trial = root_in + BIT;

    always_comb
    begin
        if (val_in >= trial)
        begin
            val_next  = val_in - trial;
            root_next = (root_in >> 1) + BIT;
        end
        else
        begin
            val_next  = val_in;
            root_next = root_in >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else
            v_reg <= v_in;
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        root_reg <= root_next;
        p_reg    <= p_in;
    end

    assign v_out    = v_reg;
    assign val_out  = val_reg;
    assign root_out = root_reg;
    assign p_out    = p_reg;

endmodule

### src/gtg_div_cell.sv
// one quotient bit of the restoring speed divider
`timescale 1ns / 1ps

module gtg_div_cell
    import gtg_pkg::*;
#(
    parameter int B  = 0,
    parameter int PW = 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             v_in,
    input  logic [REM_W-1:0] rem_in,
    input  logic [17:0]      den_in,
    input  logic [15:0]      quo_in,
    input  logic [PW-1:0]    p_in,
    output logic             v_out,
    output logic [REM_W-1:0] rem_out,
    output logic [17:0]      den_out,
    output logic [15:0]      quo_out,
    output logic [PW-1:0]    p_out
);

    logic [33:0]      sub;
    logic [REM_W-1:0] rem_next;
    logic [15:0]      quo_next;
    logic             v_reg;
    logic [REM_W-1:0] rem_reg;
    logic [17:0]      den_reg;
    logic [15:0]      quo_reg;
    logic [PW-1:0]    p_reg;

    assign sub = {16'd0, den_in} << B;

    always_comb
    begin
        rem_next = rem_in;
        quo_next = quo_in;
        if ({5'd0, rem_in} >= sub)
        begin
            rem_next    = rem_in - sub[REM_W-1:0];
            quo_next[B] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else
            v_reg <= v_in;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_in;
        quo_reg <= quo_next;
        p_reg   <= p_in;
    end

    assign v_out   = v_reg;
    assign rem_out = rem_reg;
    assign den_out = den_reg;
    assign quo_out = quo_reg;
    assign p_out   = p_reg;

endmodule

### src/gtg_checker.sv
// port-level checks of the go-to-goal steering unit and their binding
`timescale 1ns / 1ps

module gtg_checker #(
    parameter int CORDIC_STAGES = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [15:0] robot_x,
    input  logic signed [15:0] robot_y,
    input  logic signed [14:0] robot_heading,
    input  logic signed [15:0] target_x,
    input  logic signed [15:0] target_y,
    input  logic               done,
    input  logic signed [15:0] turn_rate,
    input  logic [15:0]        forward_speed,
    input  logic               at_goal,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    localparam int LAT = CORDIC_STAGES + 41;

    // every accepted item comes out after the fixed latency
    a_item_out: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted item produced no result");

    // no result without an item accepted the latency earlier
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without matching item");

    // a zero distance can never give a nonzero speed
    a_zero_dist: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && target_x == robot_x && target_y == robot_y)
        |-> ##LAT (forward_speed == 16'd0 && at_goal))
        else $error("speed nonzero at the goal");

endmodule

bind go_to_goal_steering_unit gtg_checker #(.CORDIC_STAGES(CORDIC_STAGES)) u_gtg_checker (.*);
